/* sv/gpd_pkg.sv */
// Package for the goto packet deframer.
// Holds the request types of both channels, result codes, protocol constants and the declination check.
// Used by every module of the block; depends on nothing.
package gpd_pkg;

	// Result codes carried in event_kind.
	localparam logic EVT_GOTO       = 1'b0;
	localparam logic EVT_LINK_ERROR = 1'b1;

	// Fixed protocol constants.
	localparam int unsigned HDR_LEN       = 4;
	localparam int unsigned GOTO_LEN      = 20;
	localparam logic [15:0] GOTO_KIND     = 16'd0;
	localparam logic [31:0] DEC_LIMIT     = 32'h4000_0000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       connection_start;
	} in_req_t;

	typedef struct packed {
		logic               event_kind;
		logic        [31:0] ra_angle;
		logic signed [31:0] dec_angle;
	} out_req_t;

	// Declination limited to plus or minus a quarter turn, both ends included.
	function automatic logic dec_in_range(input logic [31:0] d);
		logic [31:0] mag;
		begin
			mag = d[31] ? (32'd0 - d) : d;
			return mag <= DEC_LIMIT;
		end
	endfunction

endpackage

/* sv/goto_packet_deframer.sv */
// Top level of the goto packet deframer: input register, parser and result register.
// Depends on gpd_pkg and gpd_parser.
// Instantiates the parser between the two handshake registers.

// The deframer takes one byte of a little-endian, length-prefixed packet stream
// per request and returns a result only for a well-formed goto packet (length 20,
// type 0, declination within a quarter turn) or for a header whose length lies
// outside 4 to MAX_PACKET_LENGTH, after which the link is ignored until a byte
// arrives with connection_start set. A byte accepted into the input register sits
// there while the parser works on it, and its result, if any, is loaded into the
// result register when the parser advances, which a stalled result can delay. A
// new byte is accepted every cycle; the only thing that holds the input back is a
// result that waits in the output register while the consumer stalls, and then
// the input register also holds one byte.
module goto_packet_deframer #(
	parameter int unsigned MAX_PACKET_LENGTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  gpd_pkg::in_req_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output gpd_pkg::out_req_t result
);
	import gpd_pkg::*;

	logic      valid_s1;
	in_req_t   req_s1;
	logic      advance;
	logic      accept;
	logic      emit;
	out_req_t  rsp;
	logic      result_valid_q;
	out_req_t  result_q;

	// The parser moves forward whenever the result register is free or is
	// being emptied in this cycle.
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= item;
		end
	end

	gpd_parser #(
		.MAX_PACKET_LENGTH(MAX_PACKET_LENGTH)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (valid_s1 && advance),
		.req   (req_s1),
		.emit  (emit),
		.rsp   (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			result_q <= rsp;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* sv/gpd_parser.sv */
// Byte parser of the goto packet deframer: header, capture and link state.
// Advances one byte per enabled cycle and reports an optional result.
// Depends on gpd_pkg.
module gpd_parser #(
	parameter int unsigned MAX_PACKET_LENGTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  gpd_pkg::in_req_t req,
	output logic             emit,
	output gpd_pkg::out_req_t rsp
);
	import gpd_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_PACKET_LENGTH);
	localparam logic [16:0] MAX_LEN = 17'(MAX_PACKET_LENGTH);

	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_KIND_LO = POS_W'(2);
	localparam logic [POS_W-1:0] POS_KIND_HI = POS_W'(3);
	localparam logic [POS_W-1:0] POS_RA_LO   = POS_W'(12);
	localparam logic [POS_W-1:0] POS_RA_HI   = POS_W'(15);
	localparam logic [POS_W-1:0] POS_DEC_LO  = POS_W'(16);
	localparam logic [POS_W-1:0] POS_DEC_HI  = POS_W'(19);

	logic [POS_W-1:0] pos_q, pos_c, pos_d;
	logic [7:0]       len_lo_q, len_lo_c, len_lo_d;
	logic [15:0]      plen_q, plen_c, plen_d;
	logic [15:0]      kind_q, kind_c, kind_d;
	logic [31:0]      ra_q, ra_c, ra_d;
	logic [31:0]      dec_q, dec_c, dec_d;
	logic             closed_q, closed_c, closed_d;
	logic             pkt_end;
	logic [7:0]       b;

	assign b = req.data_byte;

	always_comb begin
		// A new connection clears everything before the byte is parsed.
		if (req.connection_start) begin
			pos_c    = '0;
			len_lo_c = '0;
			plen_c   = '0;
			kind_c   = '0;
			ra_c     = '0;
			dec_c    = '0;
			closed_c = 1'b0;
		end else begin
			pos_c    = pos_q;
			len_lo_c = len_lo_q;
			plen_c   = plen_q;
			kind_c   = kind_q;
			ra_c     = ra_q;
			dec_c    = dec_q;
			closed_c = closed_q;
		end

		pos_d    = pos_c;
		len_lo_d = len_lo_c;
		plen_d   = plen_c;
		kind_d   = kind_c;
		ra_d     = ra_c;
		dec_d    = dec_c;
		closed_d = closed_c;
		emit     = 1'b0;
		pkt_end  = 1'b0;
		rsp      = '{event_kind: EVT_GOTO, ra_angle: '0, dec_angle: '0};

		if (!closed_c) begin
			if (pos_c == POS_LEN_LO) begin
				len_lo_d = b;
			end else if (pos_c == POS_LEN_HI) begin
				plen_d = {b, len_lo_c};
			end else if (pos_c == POS_KIND_LO) begin
				kind_d = {8'd0, b};
			end else if (pos_c == POS_KIND_HI) begin
				kind_d = {b, kind_c[7:0]};
			end else if (pos_c >= POS_RA_LO && pos_c <= POS_RA_HI) begin
				ra_d[pos_c[1:0]*8 +: 8] = b;
			end else if (pos_c >= POS_DEC_LO && pos_c <= POS_DEC_HI) begin
				dec_d[pos_c[1:0]*8 +: 8] = b;
			end

			pkt_end = (pos_c >= POS_KIND_HI) &&
				(17'(pos_c) + 17'd1 >= {1'b0, plen_c});

			if (pos_c == POS_KIND_HI &&
					(plen_c < 16'(HDR_LEN) || {1'b0, plen_c} > MAX_LEN)) begin
				// Bad length: report once and ignore the link until reconnect.
				closed_d = 1'b1;
				pos_d    = '0;
				emit     = 1'b1;
				rsp.event_kind = EVT_LINK_ERROR;
			end else if (pkt_end) begin
				pos_d = '0;
				// The angles go out with the last byte folded in, then the
				// captures start over for the next packet.
				if (plen_c == 16'(GOTO_LEN) && kind_d == GOTO_KIND &&
						dec_in_range(dec_d)) begin
					emit          = 1'b1;
					rsp.ra_angle  = ra_d;
					rsp.dec_angle = dec_d;
				end
				ra_d  = '0;
				dec_d = '0;
			end else begin
				pos_d = pos_c + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_lo_q <= '0;
			plen_q   <= '0;
			kind_q   <= '0;
			ra_q     <= '0;
			dec_q    <= '0;
			closed_q <= 1'b0;
		end else if (step) begin
			pos_q    <= pos_d;
			len_lo_q <= len_lo_d;
			plen_q   <= plen_d;
			kind_q   <= kind_d;
			ra_q     <= ra_d;
			dec_q    <= dec_d;
			closed_q <= closed_d;
		end
	end

endmodule

/* sv/gpd_checker.sv */
// Port-level checker for the goto packet deframer, bound to the top level.
// Depends on gpd_pkg and goto_packet_deframer.
module gpd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input gpd_pkg::out_req_t result
);
	import gpd_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	a_goto_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_kind == EVT_GOTO |-> dec_in_range(result.dec_angle))
		else $error("goto result with declination beyond a quarter turn");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_kind == EVT_LINK_ERROR |->
			result.ra_angle == 32'd0 && result.dec_angle == 32'sd0)
		else $error("link error result with nonzero angles");

endmodule

bind goto_packet_deframer gpd_checker u_gpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
